/* rtl/string_key_hash_table_macros.svh */
// Assertion macros shared by the checker.
`ifndef STRING_KEY_HASH_TABLE_MACROS_SVH
`define STRING_KEY_HASH_TABLE_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define SKH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is applied.
`define SKH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define SKH_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/skh_pkg.sv */
package skh_pkg;

  // Commands.
  localparam logic [2:0] CMD_SET = 3'd0;
  localparam logic [2:0] CMD_GET = 3'd1;
  localparam logic [2:0] CMD_HAS = 3'd2;
  localparam logic [2:0] CMD_DEL = 3'd3;
  localparam logic [2:0] CMD_INC = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Slot marks.
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // FNV-1a 64: the prime is 2^40 + 435.
  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'd435;
  localparam int          FNV_SHIFT    = 40;

  localparam logic [6:0] MAX_ENTRIES_RST = 7'd44;

  typedef struct packed {
    logic step;
    logic clear;
  } skh_hash_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } skh_mod_stat_t;

endpackage

/* rtl/skh_if.sv */
interface skh_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [7:0]         key_byte;
  logic               last_key_byte;
  logic signed [63:0] operand_value;

  modport source (output valid, cmd, key_byte, last_key_byte, operand_value, input ready);
  modport sink (input valid, cmd, key_byte, last_key_byte, operand_value, output ready);
endinterface

interface skh_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] result_value;
  logic [6:0]         live_count;

  modport source (output valid, status, result_value, live_count, input ready);
  modport sink (input valid, status, result_value, live_count, output ready);
endinterface

/* rtl/skh_hash.sv */
module skh_hash
  import skh_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  skh_hash_ctl_t ctl,
  input  logic [7:0]    key_byte,
  output logic [63:0]   hash
);

  logic [63:0] hash_r, hash_nxt, mixed;
  logic [63:0] lo_prod;

  // One FNV-1a round: xor the byte, then multiply by the prime as shift plus small product.
  always_comb begin
    mixed    = hash_r ^ {56'd0, key_byte};
    lo_prod  = mixed * 64'(FNV_PRIME_LO);
    hash_nxt = hash_r;
    if (ctl.clear) begin
      hash_nxt = FNV_BASIS;
    end else if (ctl.step) begin
      hash_nxt = {mixed[63-FNV_SHIFT:0], {FNV_SHIFT{1'b0}}} + lo_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

  assign hash = hash_r;

endmodule

/* rtl/skh_mod.sv */
module skh_mod
  import skh_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [63:0]              hash,
  output skh_mod_stat_t            stat,
  output logic [$clog2(SLOTS)-1:0] rem
);

  localparam int SW = $clog2(SLOTS);
  // Width of the folded sum: four 16-bit chunks times weights below SLOTS.
  localparam int AW = 30;
  localparam int SH = AW + SW;

  // Weight of hash chunk k: 2^(16k) mod SLOTS.
  function automatic logic [SW-1:0] chunk_weight(input int k);
    logic [63:0] p;
    p = 64'd1 << (16 * k);
    return SW'(p % 64'(SLOTS));
  endfunction

  localparam logic [SW-1:0] W0 = chunk_weight(0);
  localparam logic [SW-1:0] W1 = chunk_weight(1);
  localparam logic [SW-1:0] W2 = chunk_weight(2);
  localparam logic [SW-1:0] W3 = chunk_weight(3);

  // Rounded-up reciprocal of SLOTS; exact for every folded sum below 2^AW.
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  logic [63:0]    src_r, src_nxt;
  logic [AW-1:0]  acc_r, acc_nxt, quo, back;
  logic [61:0]    prod_r, prod_nxt;
  logic [SW-1:0]  rem_r, rem_nxt, wt;
  logic [15+SW:0] part;
  logic [2:0]     step_r, step_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt;

  // The sequence folds the 16-bit chunks with their weights, then multiplies
  // by the reciprocal, and then subtracts quotient times SLOTS.
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    wt = W0;
      2'd1:    wt = W1;
      2'd2:    wt = W2;
      default: wt = W3;
    endcase
    part     = {{SW{1'b0}}, src_r[15:0]} * {16'd0, wt};
    quo      = AW'(prod_r >> SH);
    back     = quo * AW'(SLOTS);
    src_nxt  = src_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      src_nxt  = hash;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      priority if (step_r < 3'd4) begin
        acc_nxt = acc_r + AW'(part);
        src_nxt = {16'd0, src_r[63:16]};
      end else if (step_r == 3'd4) begin
        prod_nxt = 62'(acc_r) * 62'(RECIP[31:0]);
      end else begin
        rem_nxt  = SW'(acc_r - back);
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

/* rtl/string_key_hash_table.sv */
// Channel  | Dir | Payload                               | Request taken when
// in_req   | in  | cmd, key_byte, last_key_byte, operand | valid && ready
// out_res  | out | status, result_value, live_count      | valid && ready
// cfg      | in  | cfg_wdata (max_entries)               | cfg_we
// A key byte that is not last leaves the block idle, ready for the next byte. After the
// last byte the block starts the hash remainder by SLOTS, waits for it, probes slots and
// compares stored key bytes, acts, copies the key bytes on insert, then gives the result.
// After reset a clearing pass empties every slot mark; no request is taken meanwhile.
// A stalled result holds in the output register; key bytes of the next request are
// still taken, but its result waits in the last state.
module string_key_hash_table
  import skh_pkg::*;
#(
  parameter int SLOTS   = 64,
  parameter int KEY_MAX = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  skh_in_if.sink      in_req,
  skh_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int SW  = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int XW  = (CW > 7) ? CW : 7;
  localparam int KIW = $clog2(KEY_MAX);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MODW   = 4'd3;
  localparam logic [3:0] S_PRD    = 4'd4;
  localparam logic [3:0] S_PCK    = 4'd5;
  localparam logic [3:0] S_CRD    = 4'd6;
  localparam logic [3:0] S_CCK    = 4'd7;
  localparam logic [3:0] S_ACT    = 4'd8;
  localparam logic [3:0] S_CPRD   = 4'd9;
  localparam logic [3:0] S_CPWR   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  // Memories.
  logic [1:0]  mark_mem [SLOTS];
  logic [63:0] hash_mem [SLOTS];
  logic [63:0] val_mem  [SLOTS];
  logic [7:0]  len_mem  [SLOTS];
  logic [7:0]  ks_mem   [SLOTS*256];
  logic [7:0]  ik_mem   [KEY_MAX];

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] clr_r, clr_nxt, idx_r, idx_nxt, rem;
  logic [CW-1:0] probes_r, probes_nxt, cnt_r, cnt_nxt;
  logic [7:0]    len_r, len_nxt, j_r, j_nxt;
  logic [6:0]    max_r;
  logic [2:0]    cmd_r;
  logic [63:0]   op_r, hash;
  logic          found_r, found_nxt, empty_r, empty_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [63:0]   res_r, res_nxt, new_val;
  logic          ovld_r, ovld_nxt;
  logic [1:0]    ost_r;
  logic [63:0]   ores_r;
  logic [6:0]    ocnt_r;
  logic          accept, do_insert, fin_go;
  logic [1:0]    mark_q;
  logic [63:0]   hash_q, val_q;
  logic [7:0]    len_q, ks_q, ik_q;
  logic          mark_we;
  logic [SW-1:0] mark_wa;
  logic [1:0]    mark_wd;
  skh_hash_ctl_t hctl;
  skh_mod_stat_t mstat;

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign fin_go       = (state_r == S_FIN) && (!ovld_r || out_res.ready);

  assign hctl.step  = accept && (len_r < 8'(KEY_MAX));
  assign hctl.clear = fin_go;

  skh_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .key_byte (in_req.key_byte),
    .hash     (hash)
  );

  skh_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MSTART),
    .hash  (hash),
    .stat  (mstat),
    .rem   (rem)
  );

  // Action of the closing request.
  always_comb begin
    new_val   = (cmd_r == CMD_INC) ? val_q + op_r : op_r;
    do_insert = 1'b0;
    st_nxt    = ST_NOTFOUND;
    res_nxt   = '0;
    cnt_nxt   = cnt_r;
    mark_we   = 1'b0;
    mark_wa   = idx_r;
    mark_wd   = MARK_USED;
    unique case (cmd_r)
      CMD_SET, CMD_INC: begin
        if (found_r) begin
          st_nxt  = ST_FOUND;
          res_nxt = new_val;
        end else if (empty_r && (XW'(max_r) > XW'(cnt_r))) begin
          do_insert = 1'b1;
          st_nxt    = ST_INSERTED;
          res_nxt   = op_r;
          cnt_nxt   = cnt_r + CW'(1);
          mark_we   = 1'b1;
        end else begin
          st_nxt = ST_FULL;
        end
      end
      CMD_DEL: begin
        if (found_r) begin
          st_nxt  = ST_FOUND;
          mark_we = 1'b1;
          mark_wd = MARK_TOMB;
          if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
        if (found_r) begin
          st_nxt  = ST_FOUND;
          res_nxt = val_q;
        end
      end
    endcase
    if (state_r != S_ACT) begin
      mark_we   = 1'b0;
      do_insert = 1'b0;
      cnt_nxt   = cnt_r;
    end
    if (state_r == S_CLEAR) begin
      mark_we = 1'b1;
      mark_wa = clr_r;
      mark_wd = MARK_EMPTY;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    idx_nxt    = idx_r;
    probes_nxt = probes_r;
    j_nxt      = j_r;
    len_nxt    = len_r;
    found_nxt  = found_r;
    empty_nxt  = empty_r;
    ovld_nxt   = ovld_r && !out_res.ready;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (hctl.step) len_nxt = len_r + 8'd1;
          if (in_req.last_key_byte) state_nxt = S_MSTART;
        end
      end
      S_MSTART: state_nxt = S_MODW;
      S_MODW: begin
        if (mstat.done && !mstat.busy) begin
          idx_nxt    = rem;
          probes_nxt = '0;
          found_nxt  = 1'b0;
          empty_nxt  = 1'b0;
          state_nxt  = S_PRD;
        end
      end
      S_PRD: state_nxt = S_PCK;
      S_PCK, S_CCK: begin
        priority if (state_r == S_PCK && mark_q == MARK_EMPTY) begin
          empty_nxt = 1'b1;
          state_nxt = S_ACT;
        end else if (state_r == S_PCK && mark_q == MARK_USED && hash_q == hash
                     && len_q == len_r) begin
          j_nxt     = '0;
          state_nxt = S_CRD;
        end else if (state_r == S_CCK && ks_q == ik_q) begin
          if (j_r + 8'd1 == len_r) begin
            found_nxt = 1'b1;
            state_nxt = S_ACT;
          end else begin
            j_nxt     = j_r + 8'd1;
            state_nxt = S_CRD;
          end
        end else begin
          probes_nxt = probes_r + CW'(1);
          idx_nxt    = (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + SW'(1);
          state_nxt  = (probes_r + CW'(1) == CW'(SLOTS)) ? S_ACT : S_PRD;
        end
      end
      S_CRD: state_nxt = S_CCK;
      S_ACT: begin
        j_nxt     = '0;
        state_nxt = do_insert ? S_CPRD : S_FIN;
      end
      S_CPRD: state_nxt = S_CPWR;
      S_CPWR: begin
        j_nxt     = j_r + 8'd1;
        state_nxt = (j_r + 8'd1 == len_r) ? S_FIN : S_CPRD;
      end
      S_FIN: begin
        if (fin_go) begin
          ovld_nxt  = 1'b1;
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      max_r    <= MAX_ENTRIES_RST;
      ovld_r   <= 1'b0;
      probes_r <= '0;
      found_r  <= 1'b0;
      empty_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      ovld_r   <= ovld_nxt;
      probes_r <= probes_nxt;
      found_r  <= found_nxt;
      empty_r  <= empty_nxt;
      if (cfg_we) max_r <= cfg_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    j_r   <= j_nxt;
    if (accept && in_req.last_key_byte) begin
      cmd_r <= in_req.cmd;
      op_r  <= in_req.operand_value;
    end
    if (state_r == S_ACT) begin
      st_r  <= st_nxt;
      res_r <= res_nxt;
    end
    if (fin_go) begin
      ost_r  <= st_r;
      ores_r <= res_r;
      ocnt_r <= 7'(cnt_r);
    end
  end

  // Slot memories.
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (do_insert) begin
      hash_mem[idx_r] <= hash;
      len_mem[idx_r]  <= len_r;
    end
    if (state_r == S_ACT && (do_insert || (found_r && (cmd_r == CMD_SET
        || cmd_r == CMD_INC)))) begin
      val_mem[idx_r] <= do_insert ? op_r : new_val;
    end
    mark_q <= mark_mem[idx_r];
    hash_q <= hash_mem[idx_r];
    val_q  <= val_mem[idx_r];
    len_q  <= len_mem[idx_r];
  end

  // Key byte memories.
  always_ff @(posedge clk) begin
    if (hctl.step) ik_mem[len_r[KIW-1:0]] <= in_req.key_byte;
    if (state_r == S_CPWR) ks_mem[{idx_r, j_r}] <= ik_q;
    ks_q <= ks_mem[{idx_r, j_r}];
    ik_q <= ik_mem[j_r[KIW-1:0]];
  end

  assign out_res.valid        = ovld_r;
  assign out_res.status       = ost_r;
  assign out_res.result_value = ores_r;
  assign out_res.live_count   = ocnt_r;

endmodule

/* rtl/skh_checker.sv */
`include "string_key_hash_table_macros.svh"

module skh_checker
  import skh_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_result_value,
  input logic [6:0]  out_live_count
);

  `SKH_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `SKH_ASSERT_IMP(a_miss_zero, out_valid && (out_status == ST_NOTFOUND || out_status == ST_FULL), out_result_value == 64'd0, "miss or full with nonzero value")
  `SKH_ASSERT_IMP(a_count_bound, out_valid, 32'(out_live_count) <= SLOTS, "live count beyond slots")
  `SKH_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result valid after reset")

endmodule

bind string_key_hash_table skh_checker #(.SLOTS(SLOTS)) u_skh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .out_status       (out_res.status),
  .out_result_value (out_res.result_value),
  .out_live_count   (out_res.live_count)
);

/* tb/tb_top.sv */
module tb_top;
  import skh_pkg::*;

  localparam int NSLOT    = 64;
  localparam int KEYCAP   = 255;
  localparam int POOL     = 40;
  localparam int POOL_LEN = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_wdata;

  skh_in_if  in_req();
  skh_out_if out_res();

  string_key_hash_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // One expected lookup response.
  typedef struct {
    logic [1:0]  status;
    logic [63:0] value;
    logic [6:0]  count;
  } lookup_resp_t;

  lookup_resp_t resp_q[$];

  // Shadow copy of the table.
  logic [1:0]  tbl_mark [NSLOT];
  logic [63:0] tbl_hash [NSLOT];
  logic [63:0] tbl_value[NSLOT];
  logic [7:0]  tbl_key  [NSLOT][256];
  int          tbl_len  [NSLOT];
  int          tbl_used;
  int          entry_limit;
  logic [63:0] key_hash;
  logic [7:0]  key_bytes[KEYCAP];
  int          key_len;

  // Keys used by the tests.
  logic [7:0] pool_key[POOL][POOL_LEN];
  int         pool_len[POOL];

  int  errors;
  int  items_sent;
  bit  idle_on;
  int  sink_stall = 0;

  always #2 clk = ~clk;

  // Report one mismatch and count it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Fold one accepted request into the shadow table and queue any response.
  task automatic predict_request(logic [2:0] cmd, logic [7:0] kb, logic last,
                                 logic [63:0] opv);
    lookup_resp_t r;
    int start, idx, hit, empty_idx, j;
    bit found, has_empty, same;
    if (key_len < KEYCAP) begin
      key_bytes[key_len] = kb;
      key_len++;
      key_hash = (key_hash ^ {56'd0, kb}) * 64'd1099511628211;
    end
    if (!last) return;
    found = 0;
    has_empty = 0;
    hit = 0;
    empty_idx = 0;
    start = int'(key_hash[5:0]);
    // Linear probe: an empty slot ends the search.
    for (int i = 0; i < NSLOT; i++) begin
      idx = (start + i) % NSLOT;
      if (tbl_mark[idx] == MARK_EMPTY) begin
        empty_idx = idx;
        has_empty = 1;
        break;
      end
      if (tbl_mark[idx] == MARK_USED && tbl_hash[idx] == key_hash &&
          tbl_len[idx] == key_len) begin
        same = 1;
        for (j = 0; j < key_len; j++)
          if (tbl_key[idx][j] != key_bytes[j]) same = 0;
        if (same) begin
          found = 1;
          hit = idx;
          break;
        end
      end
    end
    r.status = ST_NOTFOUND;
    r.value = '0;
    case (cmd)
      CMD_SET, CMD_INC: begin
        if (found) begin
          if (cmd == CMD_SET) tbl_value[hit] = opv;
          else tbl_value[hit] = tbl_value[hit] + opv;
          r.status = ST_FOUND;
          r.value = tbl_value[hit];
        end else if (has_empty && tbl_used < entry_limit) begin
          tbl_mark[empty_idx] = MARK_USED;
          tbl_hash[empty_idx] = key_hash;
          tbl_value[empty_idx] = opv;
          tbl_len[empty_idx] = key_len;
          for (j = 0; j < key_len; j++) tbl_key[empty_idx][j] = key_bytes[j];
          tbl_used++;
          r.status = ST_INSERTED;
          r.value = opv;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_DEL: begin
        if (found) begin
          tbl_mark[hit] = MARK_TOMB;
          if (tbl_used > 0) tbl_used--;
          r.status = ST_FOUND;
        end
      end
      default: begin
        // Get, has and the unused codes all read the value.
        if (found) begin
          r.status = ST_FOUND;
          r.value = tbl_value[hit];
        end
      end
    endcase
    r.count = 7'(tbl_used);
    resp_q.push_back(r);
    key_hash = FNV_BASIS;
    key_len = 0;
  endtask

  // Send one request, with an optional idle burst first.
  task automatic send_request(logic [2:0] cmd, logic [7:0] kb, logic last,
                              logic [63:0] opv);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.cmd <= cmd;
    in_req.key_byte <= kb;
    in_req.last_key_byte <= last;
    in_req.operand_value <= opv;
    do @(posedge clk); while (!in_req.ready);
    items_sent++;
    predict_request(cmd, kb, last, opv);
  endtask

  // Stream a pool key; non-final bytes carry random command and operand.
  task automatic send_key(int k, logic [2:0] cmd, logic [63:0] opv);
    for (int i = 0; i < pool_len[k] - 1; i++)
      send_request(3'($urandom), pool_key[k][i], 1'b0, {$urandom, $urandom});
    send_request(cmd, pool_key[k][pool_len[k] - 1], 1'b1, opv);
  endtask

  // Fill a pool entry with fresh random bytes.
  task automatic make_key(int k, int len);
    pool_len[k] = len;
    for (int i = 0; i < len; i++) pool_key[k][i] = 8'($urandom);
  endtask

  // Stop sending and wait until every response has come back.
  task automatic drain_responses();
    in_req.valid <= 1'b0;
    while (resp_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the entry limit while the block is idle.
  task automatic write_limit(logic [6:0] v);
    drain_responses();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    entry_limit = int'(v);
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 64'h7fffffffffffffff;
      1: return 64'h8000000000000000;
      2: return 64'hffffffffffffffff;
      3: return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed cases on the reset limit.
  task automatic test_basic_commands();
    make_key(0, 3);
    make_key(1, 1);
    send_key(0, CMD_SET, 64'h7fffffffffffffff);
    send_key(0, CMD_GET, 64'd0);
    send_key(0, CMD_HAS, 64'd5);
    send_key(0, CMD_INC, 64'd1);
    send_key(0, CMD_SET, 64'h8000000000000000);
    send_key(0, CMD_INC, 64'hffffffffffffffff);
    send_key(0, 3'd7, 64'd0);
    send_key(0, 3'd5, 64'd0);
    send_key(0, CMD_DEL, 64'd0);
    send_key(0, CMD_GET, 64'd0);
    send_key(0, CMD_DEL, 64'd0);
    send_key(1, CMD_INC, 64'h8000000000000000);
    send_key(1, 3'd6, 64'd0);
    // Key holding a zero byte.
    pool_len[2] = 2;
    pool_key[2][0] = 8'h00;
    pool_key[2][1] = 8'hff;
    send_key(2, CMD_SET, 64'd9);
    send_key(2, CMD_HAS, 64'd0);
  endtask

  // Longest kept key, and an overlong key that matches its own prefix.
  task automatic test_long_keys();
    make_key(3, POOL_LEN);
    send_key(3, CMD_SET, 64'h123456789abcdef0);
    pool_len[3] = KEYCAP;
    send_key(3, CMD_GET, 64'd0);
    pool_len[3] = KEYCAP - 1;
    send_key(3, CMD_GET, 64'd0);
  endtask

  // Entry limit extremes: one entry, none, and a full-width value.
  task automatic test_entry_limit();
    write_limit(7'd1);
    make_key(4, 2);
    make_key(5, 4);
    send_key(4, CMD_SET, 64'd1);
    send_key(5, CMD_SET, 64'd2);
    send_key(5, CMD_INC, 64'd2);
    write_limit(7'd0);
    send_key(4, CMD_SET, 64'd3);
    write_limit(7'd127);
  endtask

  // Random traffic of about target items: mostly known keys, some fresh, a few long.
  task automatic test_random_traffic(logic [6:0] lim, int target);
    int k;
    logic [2:0] cmd;
    int stop;
    write_limit(lim);
    stop = items_sent + target;
    while (items_sent < stop) begin
      k = $urandom_range(0, POOL - 1);
      if ($urandom_range(0, 9) < 3) begin
        if ($urandom_range(0, 60) == 0) make_key(k, $urandom_range(200, POOL_LEN));
        else make_key(k, $urandom_range(1, 6));
      end
      case ($urandom_range(0, 9))
        0, 1, 2: cmd = CMD_SET;
        3, 4:    cmd = CMD_INC;
        5:       cmd = CMD_DEL;
        6:       cmd = CMD_HAS;
        7, 8:    cmd = CMD_GET;
        default: cmd = 3'($urandom_range(5, 7));
      endcase
      send_key(k, cmd, rand_operand());
    end
  endtask

  // Response checker and sink-side backpressure.
  always @(posedge clk) begin
    lookup_resp_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (resp_q.size() == 0) begin
        report_mismatch("unexpected response", {62'd0, out_res.status}, 64'd0);
      end else begin
        e = resp_q.pop_front();
        if (out_res.status !== e.status)
          report_mismatch("status", {62'd0, out_res.status}, {62'd0, e.status});
        if (out_res.result_value !== e.value)
          report_mismatch("result_value", out_res.result_value, e.value);
        if (out_res.live_count !== e.count)
          report_mismatch("live_count", {57'd0, out_res.live_count}, {57'd0, e.count});
      end
    end
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      out_res.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      sink_stall <= $urandom_range(0, 16);
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= 1'b1;
    end
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_req.valid <= 1'b0;
    in_req.cmd <= '0;
    in_req.key_byte <= '0;
    in_req.last_key_byte <= 1'b0;
    in_req.operand_value <= '0;
    errors = 0;
    items_sent = 0;
    idle_on = 1;
    for (int i = 0; i < NSLOT; i++) tbl_mark[i] = MARK_EMPTY;
    tbl_used = 0;
    entry_limit = int'(MAX_ENTRIES_RST);
    key_hash = FNV_BASIS;
    key_len = 0;
    for (int i = 0; i < POOL; i++) make_key(i, $urandom_range(1, 6));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_commands();
    test_long_keys();
    test_entry_limit();
    test_random_traffic(7'd64, 100);
    test_random_traffic(7'd1, 60);
    test_random_traffic(7'd20, 100);
    test_random_traffic(7'd0, 40);
    test_random_traffic(7'd64, 80);
    idle_on = 0;
    test_random_traffic(7'd44, 80);

    drain_responses();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* string_key_hash_table.f */
+incdir+rtl
rtl/skh_pkg.sv
rtl/skh_if.sv
rtl/skh_hash.sv
rtl/skh_mod.sv
rtl/string_key_hash_table.sv
rtl/skh_checker.sv
tb/tb_top.sv
